### rtl/assert_macros.svh
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int FIELD_W       = 32;
  localparam int WORD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [FIELD_W-1:0] num_a;
    logic signed [FIELD_W-1:0] den_a;
    logic signed [FIELD_W-1:0] num_b;
    logic signed [FIELD_W-1:0] den_b;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] res_num;
    logic signed [FIELD_W-1:0] res_den;
    logic [1:0]                status;
  } rsp_t;

  // classified job: three product operand pairs, sign extended words
  typedef struct packed {
    logic [1:0]                func;
    logic [1:0]                status;
    logic signed [FIELD_W-1:0] x1;
    logic signed [FIELD_W-1:0] y1;
    logic signed [FIELD_W-1:0] x2;
    logic signed [FIELD_W-1:0] y2;
    logic signed [FIELD_W-1:0] x3;
    logic signed [FIELD_W-1:0] y3;
  } job_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Classifies a request: operand checks and product operand selection.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  rau_pkg::req_t req,
  output rau_pkg::job_t job
);

  localparam int W  = WORD_BITS;
  localparam int FW = rau_pkg::FIELD_W;

  logic signed [W-1:0]  na_w, da_w, nb_w, db_w;
  logic signed [FW-1:0] na, da, nb, db;

  assign na_w = req.num_a[W-1:0];
  assign da_w = req.den_a[W-1:0];
  assign nb_w = req.num_b[W-1:0];
  assign db_w = req.den_b[W-1:0];
  assign na   = FW'(na_w);
  assign da   = FW'(da_w);
  assign nb   = FW'(nb_w);
  assign db   = FW'(db_w);

  always_comb begin
    job.func = req.func;
    if (da_w == '0 || db_w == '0) begin
      job.status = rau_pkg::STAT_ZDEN;
    end else if (req.func == rau_pkg::FUNC_DIV && nb_w == '0) begin
      job.status = rau_pkg::STAT_DIVZ;
    end else begin
      job.status = rau_pkg::STAT_OK;
    end
    job.x1 = na;
    job.y1 = db;
    job.x2 = nb;
    job.y2 = da;
    job.x3 = da;
    job.y3 = db;
    case (req.func)
      rau_pkg::FUNC_MUL: begin
        job.y1 = nb;
      end
      rau_pkg::FUNC_DIV: begin
        job.y3 = nb;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module rau_queue (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::q_ctrl_t  ctrl,
  input  rau_pkg::job_t     wr_data,
  output rau_pkg::job_t     rd_data,
  output rau_pkg::q_stat_t  stat
);

  localparam int DEPTH = rau_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rau_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rptr];

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (ctrl.wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (ctrl.rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (ctrl.wr && !ctrl.rd) begin
        count <= count + 1'b1;
      end else if (!ctrl.wr && ctrl.rd) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Executes a job: shared multiplier, binary GCD, serial division, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_back #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  rau_pkg::job_t  job,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output rau_pkg::rsp_t  rsp
);

  localparam int W  = WORD_BITS;
  localparam int FW = rau_pkg::FIELD_W;
  localparam int PW = 2 * W;
  localparam int KW = $clog2(PW + 1);
  localparam int CW = $clog2(PW);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIV, S_FIN
  } state_t;

  state_t              state;
  rau_pkg::job_t       cur;
  logic signed [PW-1:0] prod, p1, p2;
  logic [PW-1:0]       nm, dm, ga, gb, g, rn, rd;
  logic                nneg, dneg;
  logic [KW-1:0]       k;
  logic [CW-1:0]       cnt;
  logic [1:0]          st;
  logic                out_valid;
  rau_pkg::rsp_t       rsp_q;

  logic signed [W-1:0]  ma, mb;
  logic signed [PW:0]   s;
  logic [PW:0]          s_abs;
  logic [PW-1:0]        d_abs;
  logic [PW:0]          tn, td;
  logic                 gen, ged;
  logic [PW-1:0]        lim, nv, dv;
  logic                 fit;
  logic                 out_free;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign rsp      = rsp_q;
  assign out_free = !out_valid || pop;

  always_comb begin
    case (state)
      S_MUL1: begin
        ma = cur.x1[W-1:0];
        mb = cur.y1[W-1:0];
      end
      S_MUL2: begin
        ma = cur.x2[W-1:0];
        mb = cur.y2[W-1:0];
      end
      default: begin
        ma = cur.x3[W-1:0];
        mb = cur.y3[W-1:0];
      end
    endcase
  end

  always_comb begin
    case (cur.func)
      rau_pkg::FUNC_ADD: s = (PW+1)'(p1) + (PW+1)'(p2);
      rau_pkg::FUNC_SUB: s = (PW+1)'(p1) - (PW+1)'(p2);
      default:           s = (PW+1)'(p1);
    endcase
    s_abs = s[PW] ? (PW+1)'(-s) : (PW+1)'(s);
    d_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);
  end

  always_comb begin
    tn  = {rn, nm[PW-1]};
    td  = {rd, dm[PW-1]};
    gen = (tn >= {1'b0, g});
    ged = (td >= {1'b0, g});
  end

  always_comb begin
    lim = PW'(1) << (W - 1);
    fit = (nneg ? (nm <= lim) : (nm < lim)) && (dneg ? (dm <= lim) : (dm < lim));
    nv  = nneg ? PW'(-nm) : nm;
    dv  = dneg ? PW'(-dm) : dm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= job;
            st    <= job.status;
            nneg  <= 1'b0;
            dneg  <= 1'b0;
            nm    <= '0;
            dm    <= PW'(1);
            state <= (job.status == rau_pkg::STAT_OK) ? S_MUL1 : S_FIN;
          end
        end
        S_MUL1: begin
          prod  <= ma * mb;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p1    <= prod;
          prod  <= ma * mb;
          state <= S_MUL3;
        end
        S_MUL3: begin
          p2    <= prod;
          prod  <= ma * mb;
          state <= S_COMB;
        end
        S_COMB: begin
          if (s_abs == '0) begin
            state <= S_FIN;
          end else begin
            nm    <= s_abs[PW-1:0];
            dm    <= d_abs;
            nneg  <= s[PW];
            dneg  <= prod[PW-1];
            ga    <= s_abs[PW-1:0];
            gb    <= d_abs;
            k     <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          rn  <= '0;
          rd  <= '0;
          cnt <= '0;
          if (ga == '0) begin
            g     <= gb << k;
            state <= S_DIV;
          end else if (gb == '0) begin
            g     <= ga << k;
            state <= S_DIV;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            k  <= k + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DIV: begin
          rn  <= gen ? PW'(tn - {1'b0, g}) : tn[PW-1:0];
          rd  <= ged ? PW'(td - {1'b0, g}) : td[PW-1:0];
          nm  <= {nm[PW-2:0], gen};
          dm  <= {dm[PW-2:0], ged};
          cnt <= cnt + 1'b1;
          if (cnt == CW'(PW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (st == rau_pkg::STAT_OK && fit) begin
              rsp_q.res_num <= FW'($signed(nv[W-1:0]));
              rsp_q.res_den <= FW'($signed(dv[W-1:0]));
              rsp_q.status  <= rau_pkg::STAT_OK;
            end else begin
              rsp_q.res_num <= '0;
              rsp_q.res_den <= FW'(1);
              rsp_q.status  <= (st == rau_pkg::STAT_OK) ? rau_pkg::STAT_OVF : st;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RAU_ASSERT(a_err_fixed, (out_valid && rsp_q.status != rau_pkg::STAT_OK) |-> (rsp_q.res_num == '0 && rsp_q.res_den == FW'(1)), "error result not 0/1")
  `RAU_ASSERT(a_div_nonzero, (state == S_DIV) |-> (g != '0), "zero divisor in division")
  `RAU_ASSERT(a_gcd_live, (state == S_GCD) |-> (ga != '0 || gb != '0), "gcd operands both zero")
  `RAU_ASSERT(a_fin_hold, (state == S_FIN && out_valid && !pop) |=> (state == S_FIN), "result overwritten")

endmodule

### rtl/rational_arithmetic_unit.sv
// Timing: the binary GCD loop and the bit-serial double division in the back end set
// the time per transaction. The back end works on one transaction at a time and takes
// the next once its result is registered; error cases skip straight to the result.
// The front end and a two-entry queue accept transactions while the back end runs.
// Reset: synchronous, active high; clears queue, sequencer and result valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply and divide of signed fractions, reduced by GCD.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rau_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output rau_pkg::rsp_t rsp
);

  rau_pkg::job_t    job_in, job_out;
  rau_pkg::q_ctrl_t qc;
  rau_pkg::q_stat_t qs;
  logic             q_pop;

  assign full  = qs.full;
  assign qc.wr = push && !qs.full;
  assign qc.rd = q_pop;

  rau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .req (req),
    .job (job_in)
  );

  rau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (qc),
    .wr_data (job_in),
    .rd_data (job_out),
    .stat    (qs)
  );

  rau_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (job_out),
    .q_empty (qs.empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .rsp     (rsp)
  );

endmodule
